>>> src/zci_pkg.sv
// zci_pkg: shared constants and controller/datapath signal groups
// for the zero crossing interpolator; no dependencies
package zci_pkg;

  // default configuration of the index and fraction widths
  localparam int ZCI_INDEX_BITS    = 24;
  localparam int ZCI_FRACTION_BITS = 16;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int PERIOD_W = 32;
  localparam int TIME_W   = 44;

  // sample period after reset, about 1/8000 s in Q0.32
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd536871;

  // largest crossing time in Q12.32
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // the multiplier retires two period bits per step
  localparam int MUL_STEPS = PERIOD_W / 2;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic load_out;
  } zci_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic crossing;
  } zci_status_t;

endpackage

>>> src/zci_if.sv
// zci_if: valid/ready channel interfaces for samples and crossings
// depends on zci_pkg
interface zci_in_if import zci_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       block_start;

  modport source (output valid, sample, block_start, input ready);
  modport sink (input valid, sample, block_start, output ready);
  modport monitor (input valid, ready, sample, block_start);
endinterface

interface zci_out_if import zci_pkg::*;
  #(
    parameter int INDEX_BITS    = ZCI_INDEX_BITS,
    parameter int FRACTION_BITS = ZCI_FRACTION_BITS
  ) ();
  logic                     valid;
  logic                     ready;
  logic [INDEX_BITS-1:0]    crossing_index;
  logic [FRACTION_BITS-1:0] crossing_fraction;
  logic [TIME_W-1:0]        crossing_time;
  logic [INDEX_BITS-1:0]    crossing_number;

  modport source (output valid, crossing_index, crossing_fraction, crossing_time,
                  crossing_number, input ready);
  modport sink (input valid, crossing_index, crossing_fraction, crossing_time,
                crossing_number, output ready);
  modport monitor (input valid, ready, crossing_index, crossing_fraction, crossing_time,
                   crossing_number);
endinterface

>>> src/zero_crossing_interpolator_unit.sv
// zero_crossing_interpolator_unit: top level, controller plus datapath
// depends on zci_pkg, zci_if, zci_controller, zci_datapath
//
// Usage:
//   samples   - valid/ready input channel of signed 16-bit audio samples with a
//               block_start flag that makes the sample index 0 of a new block.
//   crossings - valid/ready output channel, one transaction for each sign change
//               between consecutive samples (zero samples never count): index of
//               the earlier sample, Q0.FRACTION_BITS fraction, Q12.32 time and the
//               crossing ordinal within the block.
//   cfg_we / cfg_wdata - writes the Q0.32 sample period; write only while idle.
// Timing: a sample that makes no crossing leaves the controller idle, so such
//   samples stream at one per clock. A crossing runs FRACTION_BITS divider steps,
//   a setup step, 16 radix-4 multiplier steps and a load step; samples is held
//   off until the load step, and the result is offered after it. The serial
//   divider and multiplier set the length of this sequence.
// Reset: synchronous rst clears the history, the crossing count and the output
//   valid, and sets the period to 536871 (about 1/8000 s).
// Stall: a result waits in the output register; the next sample is still taken,
//   but a further crossing holds in its last step until crossings.ready.
module zero_crossing_interpolator_unit import zci_pkg::*;
  #(
    parameter int INDEX_BITS    = ZCI_INDEX_BITS,
    parameter int FRACTION_BITS = ZCI_FRACTION_BITS
  ) (
    input  logic                clk,
    input  logic                rst,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    zci_in_if.sink              samples,
    zci_out_if.source           crossings
  );

  zci_cmd_t    cmd;
  zci_status_t status;

  // sequencer
  zci_controller #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (crossings.valid),
    .out_ready (crossings.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and history
  zci_datapath #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .sample            (samples.sample),
    .block_start       (samples.block_start),
    .cmd               (cmd),
    .status            (status),
    .crossing_index    (crossings.crossing_index),
    .crossing_fraction (crossings.crossing_fraction),
    .crossing_time     (crossings.crossing_time),
    .crossing_number   (crossings.crossing_number)
  );

endmodule

>>> src/zci_datapath.sv
// zci_datapath: sample history, serial divider, radix-4 multiplier and
// result register of the zero crossing interpolator; depends on zci_pkg
module zci_datapath import zci_pkg::*;
  #(
    parameter int INDEX_BITS    = ZCI_INDEX_BITS,
    parameter int FRACTION_BITS = ZCI_FRACTION_BITS
  ) (
    input  logic                       clk,
    input  logic                       rst,
    input  logic                       cfg_we,
    input  logic [PERIOD_W-1:0]        cfg_wdata,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       block_start,
    input  zci_cmd_t                   cmd,
    output zci_status_t                status,
    output logic [INDEX_BITS-1:0]      crossing_index,
    output logic [FRACTION_BITS-1:0]   crossing_fraction,
    output logic [TIME_W-1:0]          crossing_time,
    output logic [INDEX_BITS-1:0]      crossing_number
  );

  localparam int ABS_W  = SAMPLE_W + 1;
  localparam int DEN_W  = SAMPLE_W + 2;
  localparam int MUL_W  = INDEX_BITS + FRACTION_BITS;
  localparam int PROD_W = MUL_W + PERIOD_W;
  localparam int WIDE_W = (INDEX_BITS + PERIOD_W > TIME_W) ? INDEX_BITS + PERIOD_W : TIME_W + 1;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  // configuration register
  logic [PERIOD_W-1:0] sample_period;

  // stream history
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic                       previous_valid;
  logic [INDEX_BITS-1:0]      sample_index;
  logic [INDEX_BITS-1:0]      crossing_count;

  // operands of the transaction in flight
  logic [INDEX_BITS-1:0]    op_index;
  logic [INDEX_BITS-1:0]    op_number;
  logic [DEN_W-1:0]         rem;
  logic [DEN_W-1:0]         den;
  logic [FRACTION_BITS-1:0] quot;
  logic [MUL_W-1:0]         mcand;
  logic [MUL_W+1:0]         mcand3;
  logic [PERIOD_W-1:0]      period_sh;
  logic [PROD_W-1:0]        acc;

  // combinational values
  logic                       prev_ok;
  logic [INDEX_BITS-1:0]      count_base;
  logic [INDEX_BITS-1:0]      index_next;
  logic [INDEX_BITS-1:0]      count_next;
  logic                       crossing;
  logic signed [ABS_W-1:0]    prev_ext;
  logic signed [ABS_W-1:0]    cur_ext;
  logic [ABS_W-1:0]           prev_abs;
  logic [ABS_W-1:0]           cur_abs;
  logic [DEN_W:0]             rem_sh;
  logic [PROD_W-1:0]          addend;
  logic [WIDE_W-1:0]          whole;
  logic [TIME_W-1:0]          time_sat;

  // sign test and history update values
  always_comb begin
    prev_ok    = previous_valid && !block_start;
    count_base = block_start ? '0 : crossing_count;
    if (!prev_ok) begin
      index_next = '0;
    end else if (sample_index == INDEX_MAX) begin
      index_next = INDEX_MAX;
    end else begin
      index_next = sample_index + 1'b1;
    end
    crossing = prev_ok &&
               ((previous_sample < 0 && sample > 0) || (previous_sample > 0 && sample < 0));
    if (crossing && count_base != INDEX_MAX) begin
      count_next = count_base + 1'b1;
    end else begin
      count_next = count_base;
    end
    prev_ext = {previous_sample[SAMPLE_W-1], previous_sample};
    cur_ext  = {sample[SAMPLE_W-1], sample};
    prev_abs = prev_ext[ABS_W-1] ? ABS_W'(-prev_ext) : ABS_W'(prev_ext);
    cur_abs  = cur_ext[ABS_W-1] ? ABS_W'(-cur_ext) : ABS_W'(cur_ext);
  end

  assign status.crossing = crossing;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      sample_period <= cfg_wdata;
    end
  end

  // history registers
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      previous_valid  <= 1'b0;
      sample_index    <= '0;
      crossing_count  <= '0;
    end else if (cmd.accept) begin
      previous_sample <= sample;
      previous_valid  <= 1'b1;
      sample_index    <= index_next;
      crossing_count  <= count_next;
    end
  end

  // restoring divider step and multiplier digit
  always_comb begin
    rem_sh = {rem, 1'b0};
    unique case (period_sh[PERIOD_W-1 -: 2])
      2'd0:    addend = '0;
      2'd1:    addend = PROD_W'(mcand);
      2'd2:    addend = PROD_W'({mcand, 1'b0});
      default: addend = PROD_W'(mcand3);
    endcase
    whole    = WIDE_W'(acc[PROD_W-1:FRACTION_BITS]);
    time_sat = (whole > WIDE_W'(TIME_MAX)) ? TIME_MAX : whole[TIME_W-1:0];
  end

  // operand, divider and multiplier registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_index  <= sample_index;
      op_number <= count_next;
      rem       <= DEN_W'(prev_abs);
      den       <= DEN_W'(prev_abs) + DEN_W'(cur_abs);
      quot      <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem  <= DEN_W'(rem_sh - {1'b0, den});
        quot <= {quot[FRACTION_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[DEN_W-1:0];
        quot <= {quot[FRACTION_BITS-2:0], 1'b0};
      end
    end
    if (cmd.mul_init) begin
      mcand     <= {op_index, quot};
      mcand3    <= (MUL_W+2)'({op_index, quot}) + (MUL_W+2)'({op_index, quot, 1'b0});
      period_sh <= sample_period;
      acc       <= '0;
    end
    if (cmd.mul_step) begin
      acc       <= {acc[PROD_W-3:0], 2'b00} + addend;
      period_sh <= {period_sh[PERIOD_W-3:0], 2'b00};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      crossing_index    <= op_index;
      crossing_fraction <= quot;
      crossing_time     <= time_sat;
      crossing_number   <= op_number;
    end
  end

endmodule

>>> src/zci_controller.sv
// zci_controller: sequencer for divide, multiply and result hand-off
// of the zero crossing interpolator; depends on zci_pkg
module zci_controller import zci_pkg::*;
  #(
    parameter int FRACTION_BITS = ZCI_FRACTION_BITS
  ) (
    input  logic        clk,
    input  logic        rst,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  zci_status_t status,
    output zci_cmd_t    cmd
  );

  localparam int MAX_STEPS = (FRACTION_BITS > MUL_STEPS) ? FRACTION_BITS : MUL_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MINIT = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.accept   = in_valid && in_ready;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (cmd.accept && status.crossing) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(FRACTION_BITS - 1)) begin
          state_next = ST_MINIT;
        end
      end
      ST_MINIT: begin
        cmd.mul_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/zci_checker.sv
// zci_checker: port-level assertions for the zero crossing interpolator,
// bound to zero_crossing_interpolator_unit; depends on zci_pkg
module zci_checker import zci_pkg::*;
  #(
    parameter int INDEX_BITS    = ZCI_INDEX_BITS,
    parameter int FRACTION_BITS = ZCI_FRACTION_BITS
  ) (
    input logic                     clk,
    input logic                     rst,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [FRACTION_BITS-1:0] crossing_fraction,
    input logic [TIME_W-1:0]        crossing_time,
    input logic [INDEX_BITS-1:0]    crossing_number
  );

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("crossings.valid set after reset");

  // a crossing ordinal counts from one
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> crossing_number != '0)
    else $error("crossing number zero");

  // results take the divider and multiplier, never the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a sample transaction");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(crossing_time) &&
      $stable(crossing_number) && $stable(crossing_fraction))
    else $error("stalled crossing transaction changed");

endmodule

bind zero_crossing_interpolator_unit zci_checker #(
  .INDEX_BITS    (INDEX_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_zci_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (samples.valid),
  .in_ready          (samples.ready),
  .out_valid         (crossings.valid),
  .out_ready         (crossings.ready),
  .crossing_fraction (crossings.crossing_fraction),
  .crossing_time     (crossings.crossing_time),
  .crossing_number   (crossings.crossing_number)
);
